// File: sv/bapfm_pkg.sv
// ----------------------------------------------------------------------------
// bapfm_pkg
// Shared types, constants and the quarter-wave sine generator of the modulator.
// ----------------------------------------------------------------------------
package bapfm_pkg;

	// Stream and register port widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;
	localparam int CHAR_W      = 7;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int SPB_W       = 16;
	localparam int STEP_W      = 32;
	localparam int AMP_W       = 8;
	localparam int MAG_W       = 15;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input item kinds (carried in tuser)
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_BIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_STEP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPACE_STEP      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MARK_STEP       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_AMP_ZERO        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_AMP_ONE         = 3'd5;

	// Register reset values
	localparam logic [SPB_W-1:0]  SPB_RESET          = 16'd357;
	localparam logic [STEP_W-1:0] CARRIER_STEP_RESET = 32'd1202590843;
	localparam logic [STEP_W-1:0] SPACE_STEP_RESET   = 32'd1214616751;
	localparam logic [STEP_W-1:0] MARK_STEP_RESET    = 32'd1226642660;
	localparam logic [AMP_W-1:0]  AMP_ZERO_RESET     = 8'd48;
	localparam logic [AMP_W-1:0]  AMP_ONE_RESET      = 8'd64;

	// pi/2 and 1.0 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] SINE_FULL   = 64'd16384;

	// Per-tick status that travels with each queued tick
	typedef struct packed {
		logic bit_value;
		logic idle;
		logic char_done;
	} tick_flags_t;

	// Quarter-wave sine entry j of a table with 2^addr_bits entries, Q1.14 magnitude.
	// Evaluated at elaboration only.
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j,
			input int unsigned addr_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		x  = (64'(j) * HALF_PI_Q30) >> (addr_bits - 2);
		x2 = (x * x) >> 30;
		t  = ONE_Q30 - x2 / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		r  = (s + 64'd32768) >> 16;
		if (r > SINE_FULL) begin
			r = SINE_FULL;
		end
		return r[MAG_W-1:0];
	endfunction

endpackage

// File: sv/bapfm_front.sv
// ----------------------------------------------------------------------------
// bapfm_front
// Character buffer, bit serializer, bit timer and phase accumulators.
// ----------------------------------------------------------------------------
module bapfm_front #(
	parameter int CHAR_BITS      = 7,
	parameter int SINE_ADDR_BITS = 10,
	parameter int PHASE_BITS     = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          kind,
	input  logic [bapfm_pkg::CHAR_W-1:0]  char_value,
	input  logic [bapfm_pkg::SPB_W-1:0]   samples_per_bit,
	input  logic [PHASE_BITS-1:0]         carrier_step,
	input  logic [PHASE_BITS-1:0]         space_step,
	input  logic [PHASE_BITS-1:0]         mark_step,
	input  logic [bapfm_pkg::AMP_W-1:0]   amp_zero,
	input  logic [bapfm_pkg::AMP_W-1:0]   amp_one,
	output logic                          push,
	output logic [SINE_ADDR_BITS-1:0]     carrier_addr,
	output logic [SINE_ADDR_BITS-1:0]     fsk_addr,
	output logic [bapfm_pkg::AMP_W-1:0]   amp,
	output bapfm_pkg::tick_flags_t        flags
);
	import bapfm_pkg::*;

	localparam int LEFT_W = $clog2(CHAR_BITS + 1);

	logic [PHASE_BITS-1:0] carrier_phase_q;
	logic [PHASE_BITS-1:0] space_phase_q;
	logic [PHASE_BITS-1:0] mark_phase_q;
	logic [SPB_W-1:0]      tick_in_bit_q;
	logic [CHAR_BITS-1:0]  shift_bits_q;
	logic [LEFT_W-1:0]     bits_left_q;
	logic [CHAR_BITS-1:0]  next_char_q;
	logic                  next_char_valid_q;

	logic                  start;
	logic [CHAR_BITS-1:0]  cur_shift;
	logic [LEFT_W-1:0]     cur_left;
	logic [SPB_W-1:0]      cur_tick;
	logic [SPB_W-1:0]      tick_inc;
	logic [SPB_W-1:0]      spb_eff;
	logic                  active;
	logic                  bit_end;
	logic                  cur_bit;
	logic                  is_tick;

	assign is_tick   = accept && (kind == KIND_TICK);
	assign start     = (bits_left_q == '0) && next_char_valid_q;
	assign cur_shift = start ? next_char_q : shift_bits_q;
	assign cur_left  = start ? LEFT_W'(CHAR_BITS) : bits_left_q;
	assign cur_tick  = start ? '0 : tick_in_bit_q;
	assign active    = (cur_left != '0);
	assign cur_bit   = active && cur_shift[CHAR_BITS-1];
	assign spb_eff   = (samples_per_bit == '0) ? SPB_W'(1) : samples_per_bit;
	assign tick_inc  = cur_tick + SPB_W'(1);
	assign bit_end   = (tick_inc >= spb_eff);

	// Tick descriptor for the back end, from the phases before they advance
	assign push            = is_tick;
	assign carrier_addr    = carrier_phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign fsk_addr        = cur_bit ? mark_phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS]
	                                 : space_phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign amp             = cur_bit ? amp_one : amp_zero;
	assign flags.bit_value = cur_bit;
	assign flags.idle      = !active;
	assign flags.char_done = active && bit_end && (cur_left == LEFT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_phase_q   <= '0;
			space_phase_q     <= '0;
			mark_phase_q      <= '0;
			tick_in_bit_q     <= '0;
			shift_bits_q      <= '0;
			bits_left_q       <= '0;
			next_char_q       <= '0;
			next_char_valid_q <= 1'b0;
		end else if (accept) begin
			if (kind == KIND_LOAD) begin
				// Replace whatever is pending
				next_char_q       <= CHAR_BITS'(char_value);
				next_char_valid_q <= 1'b1;
			end else begin
				carrier_phase_q <= carrier_phase_q + carrier_step;
				space_phase_q   <= space_phase_q + space_step;
				mark_phase_q    <= mark_phase_q + mark_step;
				if (start) begin
					next_char_valid_q <= 1'b0;
				end
				if (active) begin
					if (bit_end) begin
						tick_in_bit_q <= '0;
						shift_bits_q  <= cur_shift << 1;
						bits_left_q   <= cur_left - LEFT_W'(1);
					end else begin
						tick_in_bit_q <= tick_inc;
						shift_bits_q  <= cur_shift;
						bits_left_q   <= cur_left;
					end
				end
			end
		end
	end

endmodule

// File: sv/bapfm_queue.sv
// ----------------------------------------------------------------------------
// bapfm_queue
// Small first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module bapfm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/bapfm_back.sv
// ----------------------------------------------------------------------------
// bapfm_back
// Sine lookup, keying and ASK scaling pipeline with the output register.
// ----------------------------------------------------------------------------
module bapfm_back #(
	parameter int SINE_ADDR_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  logic [SINE_ADDR_BITS-1:0]            carrier_addr,
	input  logic [SINE_ADDR_BITS-1:0]            fsk_addr,
	input  logic [bapfm_pkg::AMP_W-1:0]          amp,
	input  bapfm_pkg::tick_flags_t               flags,
	output logic                                 pop,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [bapfm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);
	import bapfm_pkg::*;

	localparam int IDX_W   = SINE_ADDR_BITS - 1;
	localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
	localparam logic [IDX_W-1:0] QUARTER_IDX = IDX_W'(QUARTER);
	localparam int PROD_W  = SAMPLE_W + AMP_W + 1;

	// Quarter-wave table, entries 0 through QUARTER
	logic [MAG_W-1:0] rom [QUARTER + 1];

	for (genvar j = 0; j <= QUARTER; j++) begin : g_rom
		localparam logic [MAG_W-1:0] ENTRY = quarter_sine(j, SINE_ADDR_BITS);
		assign rom[j] = ENTRY;
	end

	logic                       adv;

	logic                       v_s1;
	logic [IDX_W-1:0]           idx_c_s1;
	logic [IDX_W-1:0]           idx_f_s1;
	logic                       neg_c_s1;
	logic                       neg_f_s1;
	logic [AMP_W-1:0]           amp_s1;
	tick_flags_t                flags_s1;

	logic                       v_s2;
	logic [MAG_W-1:0]           mag_c_s2;
	logic [MAG_W-1:0]           mag_f_s2;
	logic                       neg_c_s2;
	logic                       neg_f_s2;
	logic [AMP_W-1:0]           amp_s2;
	tick_flags_t                flags_s2;

	logic                       v_s3;
	logic signed [SAMPLE_W-1:0] c_s3;
	logic signed [SAMPLE_W-1:0] f_s3;
	logic [AMP_W-1:0]           amp_s3;
	tick_flags_t                flags_s3;

	logic                       v_s4;
	logic signed [PROD_W-1:0]   prod_s4;
	logic signed [SAMPLE_W-1:0] psk_s4;
	logic signed [SAMPLE_W-1:0] fsk_s4;
	tick_flags_t                flags_s4;

	logic [IDX_W-1:0]           idx_c;
	logic [IDX_W-1:0]           idx_f;
	logic signed [SAMPLE_W-1:0] mag_c_sx;
	logic signed [SAMPLE_W-1:0] mag_f_sx;
	logic signed [PROD_W-1:0]   ask_round;

	logic                       m_tvalid_q;
	logic [OUT_TDATA_W-1:0]     m_tdata_q;
	logic                       m_tuser_q;
	logic                       m_tlast_q;

	// Whole pipeline moves unless a finished result is stuck at the output
	assign adv = !m_tvalid_q || m_axis_tready;
	assign pop = adv && head_valid;

	// Fold the address onto the quarter wave
	assign idx_c = carrier_addr[SINE_ADDR_BITS-2] ?
		QUARTER_IDX - {1'b0, carrier_addr[SINE_ADDR_BITS-3:0]} :
		{1'b0, carrier_addr[SINE_ADDR_BITS-3:0]};
	assign idx_f = fsk_addr[SINE_ADDR_BITS-2] ?
		QUARTER_IDX - {1'b0, fsk_addr[SINE_ADDR_BITS-3:0]} :
		{1'b0, fsk_addr[SINE_ADDR_BITS-3:0]};

	assign mag_c_sx  = $signed({1'b0, mag_c_s2});
	assign mag_f_sx  = $signed({1'b0, mag_f_s2});
	assign ask_round = (prod_s4 + PROD_W'(64)) >>> 7;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_c_s1 <= idx_c;
			idx_f_s1 <= idx_f;
			neg_c_s1 <= carrier_addr[SINE_ADDR_BITS-1];
			neg_f_s1 <= fsk_addr[SINE_ADDR_BITS-1];
			amp_s1   <= amp;
			flags_s1 <= flags;

			mag_c_s2 <= rom[idx_c_s1];
			mag_f_s2 <= rom[idx_f_s1];
			neg_c_s2 <= neg_c_s1;
			neg_f_s2 <= neg_f_s1;
			amp_s2   <= amp_s1;
			flags_s2 <= flags_s1;

			// Idle ticks give zero samples
			c_s3     <= flags_s2.idle ? '0 : (neg_c_s2 ? -mag_c_sx : mag_c_sx);
			f_s3     <= flags_s2.idle ? '0 : (neg_f_s2 ? -mag_f_sx : mag_f_sx);
			amp_s3   <= amp_s2;
			flags_s3 <= flags_s2;

			prod_s4  <= $signed({1'b0, amp_s3}) * c_s3;
			psk_s4   <= flags_s3.bit_value ? -c_s3 : c_s3;
			fsk_s4   <= f_s3;
			flags_s4 <= flags_s3;

			m_tdata_q <= {7'b0, flags_s4.bit_value, fsk_s4, psk_s4,
				ask_round[SAMPLE_W-1:0]};
			m_tuser_q <= flags_s4.idle;
			m_tlast_q <= flags_s4.char_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			v_s1       <= head_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			m_tvalid_q <= v_s4;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

endmodule

// File: sv/binary_ask_psk_fsk_modulator.sv
// ----------------------------------------------------------------------------
// binary_ask_psk_fsk_modulator
// Serializes characters and keys one carrier three ways: ASK, PSK and FSK.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser = 0 loads a character from tdata[6:0] into a
//   one-deep pending buffer (a later load replaces it); tuser = 1 is one sample
//   tick and yields exactly one output transaction. Characters go out MSB
//   first, each bit held for samples_per_bit ticks, back to back with no gap.
//   Output stream (m_axis): ASK, PSK and FSK samples plus the current data bit
//   in tdata, idle in tuser (samples are zero then), tlast on the last tick of
//   a character's last bit.
//   Throughput: one transaction per cycle in each direction while m_axis_tready
//   stays high. A tick is written into the queue at the edge that accepts it,
//   then passes fold, table read, keying, ASK multiply and the output register.
//   The multiplier and the registered sine table read set the stage count.
//   Config: cfg_we/cfg_index/cfg_data write a register at a clock edge;
//   write only while no ticks are in flight.
//   Reset: phases, timers and the pending buffer clear; registers take their
//   default values; the output goes invalid. No clearing pass is needed.
//   Stall: when a valid result meets m_axis_tready low, the result holds and the
//   back pipeline freezes; the front keeps accepting until the 4-entry queue
//   fills, then drops s_axis_tready.
// ----------------------------------------------------------------------------
module binary_ask_psk_fsk_modulator #(
	parameter int CHAR_BITS      = 7,
	parameter int SINE_ADDR_BITS = 10,
	parameter int PHASE_BITS     = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// tdata: char_value [6:0], zero pad [7]
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [bapfm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// tuser: kind [0]
	input  logic                                  s_axis_tuser,
	// tdata: ask_sample [15:0], psk_sample [31:16], fsk_sample [47:32],
	//        bit_value [48], zero pad [55:49]
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [bapfm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// tuser: idle [0]
	output logic                                  m_axis_tuser,
	// tlast: char_done
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [bapfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bapfm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bapfm_pkg::*;

	// Queue entry: carrier address, FSK address, amplitude, flags (low to high)
	localparam int FLAGS_W = $bits(tick_flags_t);
	localparam int ENTRY_W = 2 * SINE_ADDR_BITS + AMP_W + FLAGS_W;

	// Configuration registers
	logic [SPB_W-1:0]      spb_q;
	logic [PHASE_BITS-1:0] carrier_step_q;
	logic [PHASE_BITS-1:0] space_step_q;
	logic [PHASE_BITS-1:0] mark_step_q;
	logic [AMP_W-1:0]      amp_zero_q;
	logic [AMP_W-1:0]      amp_one_q;

	logic                      in_accept;
	logic                      push;
	logic [SINE_ADDR_BITS-1:0] f_carrier_addr;
	logic [SINE_ADDR_BITS-1:0] f_fsk_addr;
	logic [AMP_W-1:0]          f_amp;
	tick_flags_t               f_flags;
	logic [ENTRY_W-1:0]        push_entry;
	logic [ENTRY_W-1:0]        head_entry;
	logic                      q_full;
	logic                      q_empty;
	logic                      pop;
	tick_flags_t               head_flags;

	// Steps are cut or zero-extended to the accumulator width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q          <= SPB_RESET;
			carrier_step_q <= PHASE_BITS'(CARRIER_STEP_RESET);
			space_step_q   <= PHASE_BITS'(SPACE_STEP_RESET);
			mark_step_q    <= PHASE_BITS'(MARK_STEP_RESET);
			amp_zero_q     <= AMP_ZERO_RESET;
			amp_one_q      <= AMP_ONE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLES_PER_BIT: spb_q          <= cfg_data[SPB_W-1:0];
				REG_CARRIER_STEP:    carrier_step_q <= PHASE_BITS'(cfg_data);
				REG_SPACE_STEP:      space_step_q   <= PHASE_BITS'(cfg_data);
				REG_MARK_STEP:       mark_step_q    <= PHASE_BITS'(cfg_data);
				REG_AMP_ZERO:        amp_zero_q     <= cfg_data[AMP_W-1:0];
				REG_AMP_ONE:         amp_one_q      <= cfg_data[AMP_W-1:0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// Front takes every item while the queue has room
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	bapfm_front #(
		.CHAR_BITS      (CHAR_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.PHASE_BITS     (PHASE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (in_accept),
		.kind            (s_axis_tuser),
		.char_value      (s_axis_tdata[CHAR_W-1:0]),
		.samples_per_bit (spb_q),
		.carrier_step    (carrier_step_q),
		.space_step      (space_step_q),
		.mark_step       (mark_step_q),
		.amp_zero        (amp_zero_q),
		.amp_one         (amp_one_q),
		.push            (push),
		.carrier_addr    (f_carrier_addr),
		.fsk_addr        (f_fsk_addr),
		.amp             (f_amp),
		.flags           (f_flags)
	);

	assign push_entry = {f_flags, f_amp, f_fsk_addr, f_carrier_addr};

	bapfm_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (head_entry),
		.empty     (q_empty)
	);

	assign head_flags = tick_flags_t'(head_entry[ENTRY_W-1 -: FLAGS_W]);

	bapfm_back #(
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (!q_empty),
		.carrier_addr  (head_entry[SINE_ADDR_BITS-1:0]),
		.fsk_addr      (head_entry[2*SINE_ADDR_BITS-1 -: SINE_ADDR_BITS]),
		.amp           (head_entry[2*SINE_ADDR_BITS+AMP_W-1 -: AMP_W]),
		.flags         (head_flags),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: sv/bapfm_chk.sv
// ----------------------------------------------------------------------------
// bapfm_chk
// Port-level checks of the modulator, bound to the top level.
// ----------------------------------------------------------------------------
module bapfm_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [bapfm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input logic                                  m_axis_tuser,
	input logic                                  m_axis_tlast
);
	import bapfm_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// Idle ticks carry zero samples, bit zero and no end of character
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[48:0] == '0) && !m_axis_tlast)
		else $error("idle tick with nonzero content");

	// PSK and FSK samples stay within plus or minus one in Q1.14
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd16384)
			&& ($signed(m_axis_tdata[31:16]) >= -16'sd16384)
			&& ($signed(m_axis_tdata[47:32]) <= 16'sd16384)
			&& ($signed(m_axis_tdata[47:32]) >= -16'sd16384))
		else $error("sample out of range");

	// Nothing comes out right after reset release
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind binary_ask_psk_fsk_modulator bapfm_chk u_chk (.*);
